// ===== design/tbcc_pkg.sv =====
// Package for the time bucket charge centroid block: widths, types, defaults.
// No dependencies.
package tbcc_pkg;
  localparam int NUM_BUCKETS_DEF = 512;
  localparam int MAX_HITS_DEF    = 4096;
  localparam int QW   = 28;
  localparam int SW   = 45;
  localparam int DIVW = 46;
  localparam logic [QW-1:0] CHARGE_MAX = {QW{1'b1}};
  localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_PULL = 1'b1;

  typedef struct packed {
    logic              action;
    logic signed [15:0] position_x;
    logic signed [15:0] position_y;
    logic signed [15:0] position_z;
    logic [15:0]       charge;
    logic [9:0]        time_bucket;
  } hit_t;

  typedef struct packed {
    logic [8:0]        cluster_id;
    logic [8:0]        bucket;
    logic signed [15:0] centroid_x;
    logic signed [15:0] centroid_y;
    logic signed [15:0] first_z;
    logic [27:0]       charge_sum;
    logic              zero_charge;
    logic              none_left;
  } clus_t;

  typedef struct packed {
    logic [QW-1:0]        q;
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic signed [15:0]   z;
  } entry_t;

  function automatic logic signed [15:0] sat16(input logic signed [SW-1:0] v);
    if (v > 45'sd32767) return 16'sh7fff;
    if (v < -45'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction
endpackage

// ===== design/tbcc_if.sv =====
// Valid/ready channel carrying one item of type T.
// Depends on tbcc_pkg types at instantiation.
interface tbcc_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/time_bucket_charge_centroid.sv =====
// Time bucket charge centroid: an add stalls the input after acceptance through its
// multiply and read, read data and write back states before the next item is taken.
// A pull spends a read and a check state per bucket scanned, then two serial divides
// and an output state; a zero charge sum skips the divides. A waiting result holds a pull
// at its output state. A drain (none_left) or reset runs a clearing pass over all
// NUM_BUCKETS buckets with no item accepted. Reset is synchronous, active low.
module time_bucket_charge_centroid #(
  parameter int NUM_BUCKETS = tbcc_pkg::NUM_BUCKETS_DEF,
  parameter int MAX_HITS    = tbcc_pkg::MAX_HITS_DEF
) (
  input logic clk,
  input logic rst_n,
  tbcc_if.sink   in_ch,
  tbcc_if.source out_ch
);
  import tbcc_pkg::*;
  localparam int AW = $clog2(NUM_BUCKETS);
  localparam int HW = $clog2(MAX_HITS + 1);

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_ARD = 4'd2, S_AWR = 4'd3,
                         S_SRD = 4'd4, S_SCHK = 4'd5, S_DX = 4'd6, S_DY = 4'd7,
                         S_OUT = 4'd8, S_MUL = 4'd9;

  entry_t mem [NUM_BUCKETS];
  logic   occ [NUM_BUCKETS];
  entry_t rd_r;
  logic   occ_rd_r;

  logic [3:0] st_r, st_nxt;
  logic [AW:0] ptr_r, ptr_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [9:0] cc_r, cc_nxt;
  logic [HW-1:0] hc_r, hc_nxt;
  hit_t hit_r;
  logic signed [31:0] px_r, py_r;
  logic ov_r, ov_nxt;
  clus_t res_r, res_nxt;
  clus_t out_r, out_nxt;

  logic we, occ_we, occ_val;
  logic [AW-1:0] waddr, raddr;
  entry_t wdata;

  logic dstart;
  logic signed [SW-1:0] dnum, dq;
  logic ddone;

  tbcc_div u_div (.clk, .rst_n, .start(dstart), .num(dnum), .den(rd_r.q),
                  .done(ddone), .quot(dq));

  logic accept, out_fire;
  assign in_ch.ready = (st_r == S_IDLE);
  assign accept = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign out_ch.valid = ov_r;
  assign out_ch.data = out_r;

  logic [28:0] qs;
  logic signed [SW:0] sxs, sys;

  always_comb begin
    st_nxt = st_r; ptr_nxt = ptr_r; clr_nxt = clr_r; cc_nxt = cc_r; hc_nxt = hc_r;
    ov_nxt = ov_r; res_nxt = res_r; out_nxt = out_r;
    we = 1'b0; occ_we = 1'b0; occ_val = 1'b0; waddr = clr_r; wdata = rd_r;
    raddr = AW'(hit_r.time_bucket);
    dstart = 1'b0; dnum = rd_r.sx;
    qs = {1'b0, rd_r.q} + {13'd0, hit_r.charge};
    sxs = {rd_r.sx[SW-1], rd_r.sx} + (SW+1)'(px_r);
    sys = {rd_r.sy[SW-1], rd_r.sy} + (SW+1)'(py_r);
    if (out_fire) ov_nxt = 1'b0;
    case (st_r)
      S_CLR: begin
        occ_we = 1'b1; occ_val = 1'b0; waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(NUM_BUCKETS - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_ch.data.action == ACT_ADD) begin
            if ({22'd0, in_ch.data.time_bucket} < 32'(NUM_BUCKETS) &&
                32'(hc_r) < 32'(MAX_HITS)) begin
              hc_nxt = hc_r + 1'b1;
              st_nxt = S_MUL;
            end
          end else begin
            st_nxt = S_SRD;
          end
        end
      end
      S_MUL: st_nxt = S_ARD;
      S_ARD: st_nxt = S_AWR;
      S_AWR: begin
        we = 1'b1; waddr = AW'(hit_r.time_bucket);
        occ_we = 1'b1; occ_val = 1'b1;
        wdata.q = qs[28] ? CHARGE_MAX : qs[QW-1:0];
        wdata.sx = (sxs > (SW+1)'(SUM_MAX)) ? SUM_MAX :
                   (sxs < (SW+1)'(SUM_MIN)) ? SUM_MIN : sxs[SW-1:0];
        wdata.sy = (sys > (SW+1)'(SUM_MAX)) ? SUM_MAX :
                   (sys < (SW+1)'(SUM_MIN)) ? SUM_MIN : sys[SW-1:0];
        wdata.z = occ_rd_r ? rd_r.z : hit_r.position_z;
        if (!occ_rd_r) begin
          wdata.q = {12'd0, hit_r.charge};
          wdata.sx = SW'(px_r);
          wdata.sy = SW'(py_r);
        end
        st_nxt = S_IDLE;
      end
      S_SRD: begin
        raddr = ptr_r[AW-1:0];
        if (ptr_r >= (AW+1)'(NUM_BUCKETS)) begin
          if (!ov_r || out_fire) begin
            out_nxt = '0; out_nxt.none_left = 1'b1; ov_nxt = 1'b1;
            ptr_nxt = '0; cc_nxt = '0; hc_nxt = '0; clr_nxt = '0;
            st_nxt = S_CLR;
          end
        end else begin
          st_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        raddr = ptr_r[AW-1:0];
        if (!occ_rd_r) begin
          ptr_nxt = ptr_r + 1'b1; st_nxt = S_SRD;
        end else begin
          res_nxt = '0;
          res_nxt.cluster_id = cc_r[8:0];
          res_nxt.bucket = 9'(ptr_r);
          res_nxt.first_z = rd_r.z;
          res_nxt.charge_sum = rd_r.q;
          if (rd_r.q == '0) begin
            res_nxt.zero_charge = 1'b1; st_nxt = S_OUT;
          end else begin
            dstart = 1'b1; dnum = rd_r.sx; st_nxt = S_DX;
          end
        end
      end
      S_DX: begin
        raddr = ptr_r[AW-1:0];
        if (ddone) begin
          res_nxt.centroid_x = sat16(dq);
          dstart = 1'b1; dnum = rd_r.sy; st_nxt = S_DY;
        end
      end
      S_DY: begin
        raddr = ptr_r[AW-1:0];
        if (ddone) begin
          res_nxt.centroid_y = sat16(dq); st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || out_fire) begin
          out_nxt = res_r; ov_nxt = 1'b1;
          cc_nxt = cc_r + 10'd1; ptr_nxt = ptr_r + 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (occ_we) occ[waddr] <= occ_val;
    rd_r <= mem[raddr];
    occ_rd_r <= occ[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; ptr_r <= '0; clr_r <= '0; cc_r <= '0; hc_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ptr_r <= ptr_nxt; clr_r <= clr_nxt; cc_r <= cc_nxt;
      hc_r <= hc_nxt; ov_r <= ov_nxt;
    end
    res_r <= res_nxt;
    out_r <= out_nxt;
    if (accept) hit_r <= in_ch.data;
    px_r <= hit_r.position_x * $signed({1'b0, hit_r.charge});
    py_r <= hit_r.position_y * $signed({1'b0, hit_r.charge});
  end
endmodule

// ===== design/tbcc_div.sv =====
// Serial signed divider: quotient truncated toward zero, one bit per cycle.
// Depends on tbcc_pkg.
module tbcc_div (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic signed [tbcc_pkg::SW-1:0] num,
  input  logic [tbcc_pkg::QW-1:0] den,
  output logic done,
  output logic signed [tbcc_pkg::SW-1:0] quot
);
  import tbcc_pkg::*;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [SW-1:0] qa_r, qa_nxt;
  logic [QW:0] rem_r, rem_nxt, trial;
  logic [QW-1:0] den_r, den_nxt;
  logic [SW-1:0] mag;

  always_comb begin
    mag = num[SW-1] ? SW'(-num) : num;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    neg_nxt = neg_r; qa_nxt = qa_r; rem_nxt = rem_r; den_nxt = den_r;
    trial = '0;
    if (start) begin
      busy_nxt = 1'b1; cnt_nxt = 6'(SW); neg_nxt = num[SW-1];
      qa_nxt = mag; rem_nxt = '0; den_nxt = den;
    end else if (busy_r) begin
      trial = {rem_r[QW-1:0], qa_r[SW-1]};
      qa_nxt = {qa_r[SW-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        qa_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    neg_r <= neg_nxt; qa_r <= qa_nxt; rem_r <= rem_nxt; den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = neg_r ? SW'(-qa_r) : qa_r;
endmodule

// ===== design/tbcc_chk.sv =====
// Port checker for time_bucket_charge_centroid, bound to the top level.
// Depends on tbcc_pkg.
module tbcc_chk (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input tbcc_pkg::clus_t out_data
);
  import tbcc_pkg::*;
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.none_left |-> out_data.charge_sum == '0 &&
    out_data.cluster_id == '0) else $error("none_left fields");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_charge |-> out_data.centroid_x == '0 &&
    out_data.centroid_y == '0 && out_data.charge_sum == '0) else $error("zero");
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready) else $error("busy after reset");
endmodule

bind time_bucket_charge_centroid tbcc_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
